// ===== hdl/dowt_pkg.sv =====
// Shared types and constants for the deadline-ordered wait table.
// No dependencies.
`default_nettype none
package dowt_pkg;
    typedef enum logic [2:0] {
        CMD_AWAIT_FOR   = 3'd0,
        CMD_AWAIT_UNTIL = 3'd1,
        CMD_TRIGGER     = 3'd2,
        CMD_MONITOR     = 3'd3,
        CMD_COUNT       = 3'd4,
        CMD_ABORT       = 3'd5
    } t_cmd;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_MATCH   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_GROUP = 3'd1;
    localparam logic [2:0] ST_EVENT_0   = 3'd2;
    localparam logic [2:0] ST_GRP_FULL  = 3'd3;
    localparam logic [2:0] ST_TBL_FULL  = 3'd4;
    localparam logic [2:0] ST_NO_MATCH  = 3'd5;

    localparam logic [7:0]  ALL_GROUPS   = 8'hff;
    localparam logic [31:0] DEADLINE_MAX = 32'hffffffff;
    localparam logic [4:0]  LIVE_MAX     = 5'd31;

    // classified command handed from front to back
    typedef struct packed {
        t_cmd        cmd;
        logic        bad_group;
        logic [7:0]  group;
        logic [7:0]  event_id;
        logic [31:0] deadline;
        logic [31:0] now;
        logic        handler;
    } t_job;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [7:0]  group;
        logic [7:0]  event_id;
        logic [31:0] deadline;
        logic        run_handler;
        logic [4:0]  count;
        logic        last;
    } t_res;
endpackage
`default_nettype wire

// ===== hdl/deadline_ordered_event_wait_table.sv =====
// Deadline-ordered event wait table, top level.
// The back end walks the sorted table one entry per cycle (insert shifts,
// trigger/monitor/abort/count scans); scans stall while the output is held.
// Throughput: one item at a time in the back end; the front queue holds two.
// Reset (synchronous, active low) empties the table and zeroes group counts.
`default_nettype none
module deadline_ordered_event_wait_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int GROUP_SLOTS = 256
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_data,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [2:0]  i_command,
    input  wire [7:0]  i_group,
    input  wire [7:0]  i_event_id,
    input  wire [31:0] i_duration,
    input  wire [31:0] i_deadline_in,
    input  wire [31:0] i_now,
    input  wire        i_handler_present,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_group,
    output logic [7:0]  o_out_event,
    output logic [31:0] o_out_deadline,
    output logic        o_run_handler,
    output logic [4:0]  o_count,
    output logic        o_last
);
    import dowt_pkg::*;

    logic f_valid, f_ready, q_valid, q_ready;
    t_job f_job, q_job;
    t_res w_res;

    dowt_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_valid, .o_ready,
        .i_command, .i_group, .i_event_id, .i_duration, .i_deadline_in,
        .i_now, .i_handler_present,
        .o_valid(f_valid), .i_ready(f_ready), .o_job(f_job)
    );

    dowt_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    dowt_back #(.TABLE_DEPTH(TABLE_DEPTH), .GROUP_SLOTS(GROUP_SLOTS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .o_valid, .i_ready, .o_res(w_res)
    );

    assign o_kind         = w_res.kind;
    assign o_status       = w_res.status;
    assign o_out_group    = w_res.group;
    assign o_out_event    = w_res.event_id;
    assign o_out_deadline = w_res.deadline;
    assign o_run_handler  = w_res.run_handler;
    assign o_count        = w_res.count;
    assign o_last         = w_res.last;
endmodule
`default_nettype wire

// ===== hdl/dowt_front.sv =====
// Front end: accepts items, drops illegal commands, computes await deadlines and checks groups.
// Depends on dowt_pkg.
`default_nettype none
module dowt_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [7:0]         i_cfg_data,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire [2:0]         i_command,
    input  wire [7:0]         i_group,
    input  wire [7:0]         i_event_id,
    input  wire [31:0]        i_duration,
    input  wire [31:0]        i_deadline_in,
    input  wire [31:0]        i_now,
    input  wire               i_handler_present,
    output logic              o_valid,
    input  wire               i_ready,
    output dowt_pkg::t_job    o_job
);
    import dowt_pkg::*;

    logic [7:0] r_group_count;
    logic       r_valid;
    t_job       r_job;
    t_job       n_job;
    logic [32:0] w_sum;
    logic        w_legal;

    assign w_sum   = {1'b0, i_now} + {1'b0, i_duration};
    assign w_legal = (i_command <= CMD_ABORT);
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_comb begin
        n_job.cmd       = t_cmd'(i_command);
        n_job.bad_group = !(i_group < r_group_count);
        n_job.group     = i_group;
        n_job.event_id  = i_event_id;
        n_job.now       = i_now;
        n_job.handler   = i_handler_present;
        if (i_command == CMD_AWAIT_FOR) begin
            n_job.deadline = w_sum[32] ? DEADLINE_MAX : w_sum[31:0];
        end else begin
            n_job.deadline = i_deadline_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_group_count <= i_cfg_data;
            end
            if (o_ready) begin
                r_valid <= i_valid && w_legal;
            end
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dowt_queue.sv =====
// Two-entry item queue between front and back ends.
// Depends on dowt_pkg.
`default_nettype none
module dowt_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  dowt_pkg::t_job i_job,
    output logic           o_valid,
    input  wire            i_ready,
    output dowt_pkg::t_job o_job
);
    import dowt_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dowt_back.sv =====
// Back end: sorted entry table, per-group live counts and the walk sequencer.
// Depends on dowt_pkg.
`default_nettype none
module dowt_back #(
    parameter int TABLE_DEPTH = 16,
    parameter int GROUP_SLOTS = 256
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  dowt_pkg::t_job    i_job,
    output logic              o_valid,
    input  wire               i_ready,
    output dowt_pkg::t_res    o_res
);
    import dowt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int GW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_LIVE, S_WALK, S_INSERT, S_FINISH
    } t_state;

    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  group;
        logic [7:0]  event_id;
        logic        handler;
    } t_entry;

    t_entry      r_ent [TABLE_DEPTH];
    logic [CW-1:0] r_used;
    logic [4:0]  r_live [GROUP_SLOTS];
    logic [GROUP_SLOTS-1:0] r_live_ok;
    logic [4:0]  r_live_rd;
    t_state      r_state;
    t_job        r_job;
    logic [CW-1:0] r_idx;
    logic [4:0]  r_cnt;
    logic        r_ovalid;
    t_res        r_res;
    logic        r_dec_v;
    logic [GW-1:0] r_dec_g;
    logic [4:0]  r_dec_rd;

    logic [IW-1:0] w_ix;
    t_entry        w_e;
    logic          w_sel;
    logic          w_gslot;
    logic [GW-1:0] w_jg;
    logic [GW-1:0] w_eg;
    logic          w_oclear;
    logic          w_stop;
    logic          w_rm;

    assign w_ix     = r_idx[IW-1:0];
    assign w_e      = r_ent[w_ix];
    assign w_jg     = r_job.group[GW-1:0];
    assign w_eg     = w_e.group[GW-1:0];
    assign w_gslot  = (32'(i_job.group) < GROUP_SLOTS);
    assign w_oclear = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;
    assign o_res    = r_res;
    assign o_ready  = (r_state == S_IDLE) && w_oclear;
    assign w_stop   = (r_idx >= r_used) ||
                      (r_job.cmd == CMD_MONITOR && w_sel && w_e.deadline > r_job.now);
    assign w_rm     = (r_state == S_WALK) && w_oclear && !w_stop && w_sel &&
                      (r_job.cmd != CMD_COUNT);

    always_comb begin
        case (r_job.cmd)
            CMD_MONITOR: w_sel = (r_job.group == ALL_GROUPS) || (w_e.group == r_job.group);
            CMD_COUNT:   w_sel = (w_e.group == r_job.group) && (w_e.event_id == r_job.event_id);
            default:     w_sel = (w_e.group == r_job.group) &&
                                 ((r_job.event_id == 8'd0) || (w_e.event_id == r_job.event_id));
        endcase
    end

    function automatic t_res mk(input logic [1:0] k, input logic [2:0] s, input logic [4:0] c);
        t_res r;
        r = '0;
        r.kind   = k;
        r.status = s;
        r.count  = c;
        r.last   = 1'b1;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_live_ok <= '0;
            r_ovalid  <= 1'b0;
            r_dec_v   <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            // live count decrement of a removed entry, applied in the cycle after the removal
            r_dec_v <= w_rm && (32'(w_e.group) < GROUP_SLOTS);
            if (w_rm) begin
                r_dec_g <= w_eg;
                if (r_dec_v && r_dec_g == w_eg) begin
                    r_dec_rd <= (r_dec_rd != 5'd0) ? r_dec_rd - 5'd1 : r_dec_rd;
                end else begin
                    r_dec_rd <= r_live_ok[w_eg] ? r_live[w_eg] : 5'd0;
                end
            end
            if (r_dec_v && r_dec_rd != 5'd0) begin
                r_live[r_dec_g] <= r_dec_rd - 5'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        r_cnt <= '0;
                        if (i_job.cmd != CMD_MONITOR && (i_job.bad_group || !w_gslot)) begin
                            r_res    <= mk(KIND_DONE, ST_BAD_GROUP, 5'd0);
                            r_ovalid <= 1'b1;
                        end else if ((i_job.cmd == CMD_AWAIT_FOR ||
                                      i_job.cmd == CMD_AWAIT_UNTIL) &&
                                     i_job.event_id == 8'd0) begin
                            r_res    <= mk(KIND_DONE, ST_EVENT_0, 5'd0);
                            r_ovalid <= 1'b1;
                        end else begin
                            r_state <= S_LIVE;
                        end
                    end
                end
                S_LIVE: begin
                    // live count read for await checks and wildcard count
                    r_live_rd <= r_live_ok[w_jg] ? r_live[w_jg] : 5'd0;
                    if (r_job.cmd == CMD_AWAIT_FOR || r_job.cmd == CMD_AWAIT_UNTIL ||
                        (r_job.cmd == CMD_COUNT && r_job.event_id == 8'd0)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_FINISH: begin
                    if (w_oclear) begin
                        if (r_job.cmd == CMD_COUNT) begin
                            r_res    <= mk(KIND_DONE, ST_OK, r_live_rd);
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (r_live_rd >= LIVE_MAX) begin
                            r_res    <= mk(KIND_DONE, ST_GRP_FULL, 5'd0);
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (32'(r_used) >= TABLE_DEPTH) begin
                            r_res    <= mk(KIND_DONE, ST_TBL_FULL, 5'd0);
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_idx   <= r_used;
                            r_state <= S_INSERT;
                        end
                    end
                end
                S_INSERT: begin
                    // shift entries up from the tail, one per cycle
                    if (r_idx != '0 && r_ent[w_ix - 1'b1].deadline > r_job.deadline) begin
                        r_ent[w_ix] <= r_ent[w_ix - 1'b1];
                        r_idx       <= r_idx - 1'b1;
                    end else begin
                        r_ent[w_ix] <= '{r_job.deadline, r_job.group, r_job.event_id,
                                        r_job.handler};
                        r_used          <= r_used + 1'b1;
                        r_live[w_jg]    <= r_live_rd + 5'd1;
                        r_live_ok[w_jg] <= 1'b1;
                        r_res <= '{KIND_DONE, ST_OK, r_job.group, r_job.event_id,
                                   r_job.deadline, r_job.handler, 5'd0, 1'b1};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_WALK: begin
                    if (w_oclear) begin
                        if (w_stop) begin
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                            if (r_job.cmd == CMD_TRIGGER) begin
                                r_res <= mk(KIND_DONE, ST_NO_MATCH, 5'd0);
                            end else begin
                                r_res <= mk(KIND_DONE, ST_OK, r_cnt);
                            end
                        end else if (w_sel && r_job.cmd != CMD_COUNT) begin
                            // remove entry: shift tail down over it
                            for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
                                if (k >= 32'(r_idx) && k + 1 < 32'(r_used)) begin
                                    r_ent[k] <= r_ent[k + 1];
                                end
                            end
                            r_used <= r_used - 1'b1;
                            if (r_cnt != LIVE_MAX) begin
                                r_cnt <= r_cnt + 5'd1;
                            end
                            if (r_job.cmd == CMD_MONITOR) begin
                                r_res <= '{KIND_TIMEOUT, ST_OK, w_e.group, w_e.event_id,
                                           w_e.deadline, 1'b1, 5'd0, 1'b0};
                                r_ovalid <= 1'b1;
                            end else if (r_job.cmd == CMD_TRIGGER) begin
                                r_res <= '{KIND_MATCH, ST_OK, w_e.group, w_e.event_id,
                                           w_e.deadline, w_e.handler, 5'd0, 1'b1};
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end else begin
                            if (w_sel && r_cnt != LIVE_MAX) begin
                                r_cnt <= r_cnt + 5'd1;
                            end
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
